// ----- sv/sgr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg: shared types, codes and color tables of the SGR attribute decoder
// Holds the parameter codes, the state struct passed between the decode logic
// and the top level, and the sixteen-entry base color table.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // Parameter word width and the byte-padded stream width that carries it
  localparam int PARAM_BITS  = 16;
  localparam int IN_TDATA_W  = ((PARAM_BITS + 7) / 8) * 8;
  localparam int COLOR_W     = 24;
  localparam int STYLE_W     = 6;
  localparam int ATTR_W      = 2 * COLOR_W + STYLE_W;
  localparam int OUT_TDATA_W = ((ATTR_W + 7) / 8) * 8;

  typedef logic [PARAM_BITS-1:0] sgr_param_t;
  typedef logic [COLOR_W-1:0]    sgr_color_t;

  // Reset values of the default color registers
  localparam sgr_color_t DEF_FG_RESET = 24'hE5E5E5;
  localparam sgr_color_t DEF_BG_RESET = 24'h000000;

  // Configuration register indexes
  localparam logic CFG_DEF_FG = 1'b0;
  localparam logic CFG_DEF_BG = 1'b1;

  // Style flag positions
  localparam int STY_BOLD   = 0;
  localparam int STY_DIM    = 1;
  localparam int STY_ITALIC = 2;
  localparam int STY_UNDER  = 3;
  localparam int STY_INV    = 4;
  localparam int STY_STRIKE = 5;

  // SGR parameter codes
  localparam sgr_param_t CODE_RESET          = PARAM_BITS'(0);
  localparam sgr_param_t CODE_BOLD           = PARAM_BITS'(1);
  localparam sgr_param_t CODE_DIM            = PARAM_BITS'(2);
  localparam sgr_param_t CODE_ITALIC         = PARAM_BITS'(3);
  localparam sgr_param_t CODE_UNDER          = PARAM_BITS'(4);
  localparam sgr_param_t CODE_INVERSE        = PARAM_BITS'(7);
  localparam sgr_param_t CODE_STRIKE         = PARAM_BITS'(9);
  localparam sgr_param_t CODE_BOLD_OFF       = PARAM_BITS'(21);
  localparam sgr_param_t CODE_NORMAL         = PARAM_BITS'(22);
  localparam sgr_param_t CODE_ITALIC_OFF     = PARAM_BITS'(23);
  localparam sgr_param_t CODE_UNDER_OFF      = PARAM_BITS'(24);
  localparam sgr_param_t CODE_INVERSE_OFF    = PARAM_BITS'(27);
  localparam sgr_param_t CODE_STRIKE_OFF     = PARAM_BITS'(29);
  localparam sgr_param_t CODE_FG_BASE        = PARAM_BITS'(30);
  localparam sgr_param_t CODE_FG_LAST        = PARAM_BITS'(37);
  localparam sgr_param_t CODE_FG_EXT         = PARAM_BITS'(38);
  localparam sgr_param_t CODE_FG_DEFAULT     = PARAM_BITS'(39);
  localparam sgr_param_t CODE_BG_BASE        = PARAM_BITS'(40);
  localparam sgr_param_t CODE_BG_LAST        = PARAM_BITS'(47);
  localparam sgr_param_t CODE_BG_EXT         = PARAM_BITS'(48);
  localparam sgr_param_t CODE_BG_DEFAULT     = PARAM_BITS'(49);
  localparam sgr_param_t CODE_FG_BRIGHT      = PARAM_BITS'(90);
  localparam sgr_param_t CODE_FG_BRIGHT_LAST = PARAM_BITS'(97);
  localparam sgr_param_t CODE_BG_BRIGHT      = PARAM_BITS'(100);
  localparam sgr_param_t CODE_BG_BRIGHT_LAST = PARAM_BITS'(107);

  // Selectors following 38 / 48
  localparam sgr_param_t SEL_INDEXED = PARAM_BITS'(5);
  localparam sgr_param_t SEL_RGB     = PARAM_BITS'(2);

  // Palette geometry
  localparam logic [7:0] PAL_CUBE_FIRST = 8'd16;
  localparam logic [7:0] PAL_GRAY_FIRST = 8'd232;
  localparam logic [7:0] CUBE_BASE      = 8'd55;
  localparam logic [7:0] CUBE_STEP      = 8'd40;
  localparam logic [7:0] GRAY_BASE      = 8'd8;
  localparam logic [7:0] GRAY_STEP      = 8'd10;

  // Extended color phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INTRO,
    PH_INDEX,
    PH_RGB
  } sgr_phase_t;

  typedef struct packed {
    logic [STYLE_W-1:0] style;
    sgr_color_t         bg;
    sgr_color_t         fg;
  } sgr_attr_t;

  // Full decoder state, current or next
  typedef struct packed {
    sgr_attr_t  attr;
    sgr_phase_t phase;
    logic       tgt_bg;
    logic [1:0] held_cnt;
    sgr_param_t held0;
    sgr_param_t held1;
  } sgr_state_t;

  // Standard and bright base colors
  function automatic sgr_color_t sgr_base16(input logic [3:0] idx);
    sgr_color_t c;
    unique case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hCD0000;
      4'd2:    c = 24'h00CD00;
      4'd3:    c = 24'hCDCD00;
      4'd4:    c = 24'h0000EE;
      4'd5:    c = 24'hCD00CD;
      4'd6:    c = 24'h00CDCD;
      4'd7:    c = 24'hE5E5E5;
      4'd8:    c = 24'h7F7F7F;
      4'd9:    c = 24'hFF0000;
      4'd10:   c = 24'h00FF00;
      4'd11:   c = 24'hFFFF00;
      4'd12:   c = 24'h5C5CFF;
      4'd13:   c = 24'hFF00FF;
      4'd14:   c = 24'h00FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/sgr_attribute_decoder.sv -----
`timescale 1ns / 1ps
// A parameter word is registered on input and decoded from that register;
// the attribute word for a last parameter is loaded into the output register
// when that decoded word advances, and is held there until it is taken.
// Throughput: one parameter word per cycle, set by the single decode stage;
// input stalls only while a last word waits on an output word not yet taken.
// Reset (rst_n low, synchronous) restores default colors 0xE5E5E5 / 0x000000,
// clears the style flags and drops any open extended color form.
// ----------------------------------------------------------------------------
// sgr_attribute_decoder: SGR parameter stream to text attribute word
// Input register, combinational decode against the attribute state, and an
// output register that holds the attribute word of each finished sequence.
// ----------------------------------------------------------------------------
module sgr_attribute_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [sgr_pkg::COLOR_W-1:0]       cfg_wdata,
  // parameter stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sgr_pkg::IN_TDATA_W-1:0]    in_tdata,   // param_value
  input  logic                              in_tlast,   // last_param
  // attribute stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fg_color, bg_color, bold_on, dim_on, italic_on, underline_on, inverse_on,
  // strike_on, zero pad
  output logic [sgr_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // configuration
  sgr_pkg::sgr_color_t def_fg_r;
  sgr_pkg::sgr_color_t def_bg_r;

  // input stage
  logic                s1_valid_r;
  sgr_pkg::sgr_param_t s1_param_r;
  logic                s1_last_r;
  logic                s1_fire;

  // attribute state
  sgr_pkg::sgr_attr_t  attr_r;
  sgr_pkg::sgr_phase_t phase_r;
  logic                tgt_bg_r;
  logic [1:0]          held_cnt_r;
  sgr_pkg::sgr_param_t held0_r;
  sgr_pkg::sgr_param_t held1_r;
  sgr_pkg::sgr_state_t cur_state;
  sgr_pkg::sgr_state_t state_nxt;

  // output stage
  logic                out_valid_r;
  logic                out_valid_nxt;
  sgr_pkg::sgr_attr_t  out_attr_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_fg_r <= sgr_pkg::DEF_FG_RESET;
      def_bg_r <= sgr_pkg::DEF_BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sgr_pkg::CFG_DEF_FG: def_fg_r <= cfg_wdata;
        sgr_pkg::CFG_DEF_BG: def_bg_r <= cfg_wdata;
        default:             def_fg_r <= def_fg_r;
      endcase
    end
  end

  // advance the input word unless a last word waits on a full output
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_param_r <= in_tdata[sgr_pkg::PARAM_BITS-1:0];
      s1_last_r  <= in_tlast;
    end
  end

  // decode
  always_comb begin
    cur_state.attr     = attr_r;
    cur_state.phase    = phase_r;
    cur_state.tgt_bg   = tgt_bg_r;
    cur_state.held_cnt = held_cnt_r;
    cur_state.held0    = held0_r;
    cur_state.held1    = held1_r;
  end

  sgr_decode u_decode (
    .cur    (cur_state),
    .v      (s1_param_r),
    .last   (s1_last_r),
    .def_fg (def_fg_r),
    .def_bg (def_bg_r),
    .nxt    (state_nxt)
  );

  // commit state on each decoded word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r     <= '{style: '0, bg: sgr_pkg::DEF_BG_RESET, fg: sgr_pkg::DEF_FG_RESET};
      phase_r    <= sgr_pkg::PH_IDLE;
      tgt_bg_r   <= 1'b0;
      held_cnt_r <= 2'd0;
    end else if (s1_fire) begin
      attr_r     <= state_nxt.attr;
      phase_r    <= state_nxt.phase;
      tgt_bg_r   <= state_nxt.tgt_bg;
      held_cnt_r <= state_nxt.held_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      held0_r <= state_nxt.held0;
      held1_r <= state_nxt.held1;
    end
  end

  // output register: load on a last word, drop when taken
  always_comb begin
    priority if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_attr_r <= state_nxt.attr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sgr_pkg::OUT_TDATA_W'({out_attr_r.style, out_attr_r.bg, out_attr_r.fg});

  // checks
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (phase_r == sgr_pkg::PH_IDLE && held_cnt_r == 2'd0))
    else $error("extended form left open after last word");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd3)
    else $error("held count out of range");

  a_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r != 2'd0) |-> (phase_r == sgr_pkg::PH_RGB))
    else $error("held words outside RGB form");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_last_r))
    else $error("result without a last word");

  a_mid_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_last_r) |-> s1_fire)
    else $error("non-last word stalled");

endmodule

// ----- sv/sgr_palette.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_palette: 256-color palette lookup
// Base colors from the table, the 6x6x6 cube and the gray ramp computed with
// reciprocal multiplies in place of division.
// ----------------------------------------------------------------------------
module sgr_palette (
  input  logic [7:0]          idx,
  output sgr_pkg::sgr_color_t color
);

  logic [7:0]  cube_idx;
  logic [13:0] red_prod;
  logic [2:0]  red_i;
  logic [5:0]  rem36;
  logic [10:0] grn_prod;
  logic [2:0]  grn_i;
  logic [2:0]  blu_i;
  logic [4:0]  gray_n;
  logic [7:0]  gray_lvl;

  function automatic logic [7:0] cube_level(input logic [2:0] v);
    logic [7:0] lvl;
    if (v == 3'd0) begin
      lvl = 8'd0;
    end else begin
      lvl = sgr_pkg::CUBE_BASE + 8'({5'b0, v} * sgr_pkg::CUBE_STEP);
    end
    return lvl;
  endfunction

  // Split cube index into r/g/b digits: /36 as *57>>11, /6 as *43>>8
  always_comb begin
    cube_idx = idx - sgr_pkg::PAL_CUBE_FIRST;
    red_prod = 14'(cube_idx) * 14'd57;
    red_i    = red_prod[13:11];
    rem36    = 6'(cube_idx - 8'({5'b0, red_i} * 8'd36));
    grn_prod = 11'(rem36) * 11'd43;
    grn_i    = grn_prod[10:8];
    blu_i    = 3'(rem36 - 6'({3'b0, grn_i} * 6'd6));
    gray_n   = 5'(idx - sgr_pkg::PAL_GRAY_FIRST);
    gray_lvl = sgr_pkg::GRAY_BASE + 8'({3'b0, gray_n} * sgr_pkg::GRAY_STEP);
  end

  // Select region
  always_comb begin
    priority if (idx < sgr_pkg::PAL_CUBE_FIRST) begin
      color = sgr_pkg::sgr_base16(idx[3:0]);
    end else if (idx < sgr_pkg::PAL_GRAY_FIRST) begin
      color = {cube_level(red_i), cube_level(grn_i), cube_level(blu_i)};
    end else begin
      color = {gray_lvl, gray_lvl, gray_lvl};
    end
  end

endmodule

// ----- sv/sgr_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_decode: next-state logic for one SGR parameter word
// Applies plain codes, tracks the 38/48 extended forms and replays the held
// parameters of a truncated RGB form as ordinary codes.
// ----------------------------------------------------------------------------
module sgr_decode (
  input  sgr_pkg::sgr_state_t cur,
  input  sgr_pkg::sgr_param_t v,
  input  logic                last,
  input  sgr_pkg::sgr_color_t def_fg,
  input  sgr_pkg::sgr_color_t def_bg,
  output sgr_pkg::sgr_state_t nxt
);

  sgr_pkg::sgr_color_t pal_color;
  sgr_pkg::sgr_color_t ext_color;
  sgr_pkg::sgr_phase_t replay_ph;
  logic                replay_tgt;
  sgr_pkg::sgr_color_t rgb_color;

  sgr_palette u_palette (
    .idx   (v[7:0]),
    .color (pal_color)
  );

  function automatic logic [7:0] clamp8(input sgr_pkg::sgr_param_t p);
    return ((p >> 8) != '0) ? 8'hFF : p[7:0];
  endfunction

  function automatic logic is_ext(input sgr_pkg::sgr_param_t p);
    return (p == sgr_pkg::CODE_FG_EXT) || (p == sgr_pkg::CODE_BG_EXT);
  endfunction

  function automatic sgr_pkg::sgr_attr_t set_target(input sgr_pkg::sgr_attr_t a,
                                                    input logic tgt_bg,
                                                    input sgr_pkg::sgr_color_t c);
    sgr_pkg::sgr_attr_t r;
    r = a;
    if (tgt_bg) begin
      r.bg = c;
    end else begin
      r.fg = c;
    end
    return r;
  endfunction

  // Apply one ordinary code to the attributes
  function automatic sgr_pkg::sgr_attr_t plain_code(input sgr_pkg::sgr_attr_t a,
                                                    input sgr_pkg::sgr_param_t p,
                                                    input sgr_pkg::sgr_color_t dfg,
                                                    input sgr_pkg::sgr_color_t dbg);
    sgr_pkg::sgr_attr_t r;
    r = a;
    unique case (p)
      sgr_pkg::CODE_RESET: begin
        r.style = '0;
        r.fg    = dfg;
        r.bg    = dbg;
      end
      sgr_pkg::CODE_BOLD:        r.style[sgr_pkg::STY_BOLD]   = 1'b1;
      sgr_pkg::CODE_DIM:         r.style[sgr_pkg::STY_DIM]    = 1'b1;
      sgr_pkg::CODE_ITALIC:      r.style[sgr_pkg::STY_ITALIC] = 1'b1;
      sgr_pkg::CODE_UNDER:       r.style[sgr_pkg::STY_UNDER]  = 1'b1;
      sgr_pkg::CODE_INVERSE:     r.style[sgr_pkg::STY_INV]    = 1'b1;
      sgr_pkg::CODE_STRIKE:      r.style[sgr_pkg::STY_STRIKE] = 1'b1;
      sgr_pkg::CODE_BOLD_OFF:    r.style[sgr_pkg::STY_BOLD]   = 1'b0;
      sgr_pkg::CODE_NORMAL: begin
        r.style[sgr_pkg::STY_BOLD] = 1'b0;
        r.style[sgr_pkg::STY_DIM]  = 1'b0;
      end
      sgr_pkg::CODE_ITALIC_OFF:  r.style[sgr_pkg::STY_ITALIC] = 1'b0;
      sgr_pkg::CODE_UNDER_OFF:   r.style[sgr_pkg::STY_UNDER]  = 1'b0;
      sgr_pkg::CODE_INVERSE_OFF: r.style[sgr_pkg::STY_INV]    = 1'b0;
      sgr_pkg::CODE_STRIKE_OFF:  r.style[sgr_pkg::STY_STRIKE] = 1'b0;
      sgr_pkg::CODE_FG_DEFAULT:  r.fg = dfg;
      sgr_pkg::CODE_BG_DEFAULT:  r.bg = dbg;
      default: begin
        if (p >= sgr_pkg::CODE_FG_BASE && p <= sgr_pkg::CODE_FG_LAST) begin
          r.fg = sgr_pkg::sgr_base16({1'b0, 3'(p - sgr_pkg::CODE_FG_BASE)});
        end else if (p >= sgr_pkg::CODE_BG_BASE && p <= sgr_pkg::CODE_BG_LAST) begin
          r.bg = sgr_pkg::sgr_base16({1'b0, 3'(p - sgr_pkg::CODE_BG_BASE)});
        end else if (p >= sgr_pkg::CODE_FG_BRIGHT && p <= sgr_pkg::CODE_FG_BRIGHT_LAST) begin
          r.fg = sgr_pkg::sgr_base16({1'b1, 3'(p - sgr_pkg::CODE_FG_BRIGHT)});
        end else if (p >= sgr_pkg::CODE_BG_BRIGHT && p <= sgr_pkg::CODE_BG_BRIGHT_LAST) begin
          r.bg = sgr_pkg::sgr_base16({1'b1, 3'(p - sgr_pkg::CODE_BG_BRIGHT)});
        end
      end
    endcase
    return r;
  endfunction

  // Indexed color, out-of-range index falls back to default foreground
  assign ext_color = ((v >> 8) == '0) ? pal_color : def_fg;
  assign rgb_color = {clamp8(cur.held0), clamp8(cur.held1), clamp8(v)};

  always_comb begin
    nxt        = cur;
    replay_ph  = sgr_pkg::PH_IDLE;
    replay_tgt = cur.tgt_bg;
    unique case (cur.phase)
      sgr_pkg::PH_INTRO: begin
        nxt.phase = sgr_pkg::PH_IDLE;
        if (v == sgr_pkg::SEL_INDEXED) begin
          if (last) begin
            nxt.attr = set_target(cur.attr, cur.tgt_bg, def_fg);
          end else begin
            nxt.phase = sgr_pkg::PH_INDEX;
          end
        end else if (v == sgr_pkg::SEL_RGB) begin
          if (last) begin
            nxt.attr = set_target(cur.attr, cur.tgt_bg, def_fg);
            nxt.attr = plain_code(nxt.attr, sgr_pkg::CODE_DIM, def_fg, def_bg);
          end else begin
            nxt.phase    = sgr_pkg::PH_RGB;
            nxt.held_cnt = 2'd0;
          end
        end else if (is_ext(v)) begin
          // selector is itself a new extended code
          if (!last) begin
            nxt.phase  = sgr_pkg::PH_INTRO;
            nxt.tgt_bg = (v == sgr_pkg::CODE_BG_EXT);
          end
        end else begin
          nxt.attr = plain_code(cur.attr, v, def_fg, def_bg);
        end
      end
      sgr_pkg::PH_INDEX: begin
        nxt.phase = sgr_pkg::PH_IDLE;
        nxt.attr  = set_target(cur.attr, cur.tgt_bg, ext_color);
      end
      sgr_pkg::PH_RGB: begin
        if (cur.held_cnt == 2'd2) begin
          nxt.phase    = sgr_pkg::PH_IDLE;
          nxt.held_cnt = 2'd0;
          nxt.attr     = set_target(cur.attr, cur.tgt_bg, rgb_color);
        end else if (last) begin
          // truncated: fall back, then replay held words as fresh codes
          nxt.phase    = sgr_pkg::PH_IDLE;
          nxt.held_cnt = 2'd0;
          nxt.attr     = set_target(cur.attr, cur.tgt_bg, def_fg);
          nxt.attr     = plain_code(nxt.attr, sgr_pkg::CODE_DIM, def_fg, def_bg);
          if (cur.held_cnt == 2'd1) begin
            if (is_ext(cur.held0)) begin
              replay_ph  = sgr_pkg::PH_INTRO;
              replay_tgt = (cur.held0 == sgr_pkg::CODE_BG_EXT);
            end else begin
              nxt.attr = plain_code(nxt.attr, cur.held0, def_fg, def_bg);
            end
          end
          nxt.tgt_bg = replay_tgt;
          if (replay_ph == sgr_pkg::PH_INTRO &&
              (v == sgr_pkg::SEL_INDEXED || v == sgr_pkg::SEL_RGB)) begin
            nxt.attr = set_target(nxt.attr, replay_tgt, def_fg);
            if (v == sgr_pkg::SEL_RGB) begin
              nxt.attr = plain_code(nxt.attr, sgr_pkg::CODE_DIM, def_fg, def_bg);
            end
          end else if (!is_ext(v)) begin
            nxt.attr = plain_code(nxt.attr, v, def_fg, def_bg);
          end
        end else begin
          // hold the channel word
          if (cur.held_cnt[0]) begin
            nxt.held1 = v;
          end else begin
            nxt.held0 = v;
          end
          nxt.held_cnt = cur.held_cnt + 2'd1;
        end
      end
      default: begin
        nxt.phase = sgr_pkg::PH_IDLE;
        if (is_ext(v)) begin
          if (!last) begin
            nxt.phase  = sgr_pkg::PH_INTRO;
            nxt.tgt_bg = (v == sgr_pkg::CODE_BG_EXT);
          end
        end else begin
          nxt.attr = plain_code(cur.attr, v, def_fg, def_bg);
        end
      end
    endcase
    // sequence end drops any open extended form
    if (last) begin
      nxt.phase    = sgr_pkg::PH_IDLE;
      nxt.held_cnt = 2'd0;
    end
  end

endmodule

// ----- tb/tb_sgr_attribute_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sgr_attribute_decoder: self-checking bench for the SGR attribute decoder
// Feeds a directed table of parameter words and then random SGR sequences.
// The sequences are mostly well-formed, with indexed and RGB extended colors,
// truncated extended forms and noise. Random idle cycles fall on both sides.
// One long output hold-off fills the block and stalls its input. Each
// attribute word is compared field by field with a model of the attribute
// state or a typed directed row, over several default color settings.
// ----------------------------------------------------------------------------
module tb_sgr_attribute_decoder;
  import sgr_pkg::*;

  localparam int        CYCLE_LIMIT  = 200000;
  localparam int        PHASE_ITEMS  = 120;
  localparam int        HOLD_CYCLES  = 400;
  localparam int        DRAIN_CYCLES = 4;
  localparam int        IDLE_PCT     = 20;
  localparam int        BRIGHT_OFS   = 8;
  localparam int        NUM_ROWS     = 28;
  // base color table, entry 0 in the lowest bits
  localparam logic [16*COLOR_W-1:0] BASE_COLORS = {
    24'hFFFFFF, 24'h00FFFF, 24'hFF00FF, 24'h5C5CFF,
    24'hFFFF00, 24'h00FF00, 24'hFF0000, 24'h7F7F7F,
    24'hE5E5E5, 24'h00CDCD, 24'hCD00CD, 24'h0000EE,
    24'hCDCD00, 24'h00CD00, 24'hCD0000, 24'h000000
  };

  typedef struct packed {
    sgr_param_t value;
    logic       last;
    logic       typed;
    sgr_attr_t  attr;
  } dir_row_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic                    cfg_addr   = 1'b0;
  logic [COLOR_W-1:0]      cfg_wdata  = '0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;   // param_value
  logic                    in_tlast   = 1'b0; // last_param
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // fg_color, bg_color, bold_on, dim_on, italic_on, underline_on, inverse_on,
  // strike_on, zero pad
  logic [OUT_TDATA_W-1:0]  out_tdata;

  // Model of the attribute state
  sgr_color_t  def_fg;
  sgr_color_t  def_bg;
  sgr_color_t  cur_fg;
  sgr_color_t  cur_bg;
  logic [5:0]  cur_style;
  sgr_phase_t  ext_phase;
  logic        ext_to_bg;
  logic [1:0]  held_n;
  sgr_param_t  held_w [2];

  sgr_attr_t   attr_q [$];
  int          errors     = 0;
  int          cycles     = 0;
  int          items_sent = 0;
  logic        calm       = 1'b0;
  logic        hold_req   = 1'b0;
  logic        hold_done  = 1'b0;
  int          hold_left  = 0;

  string       style_names [6] = '{"bold_on", "dim_on", "italic_on",
                                   "underline_on", "inverse_on", "strike_on"};
  sgr_param_t  style_codes [15] = '{CODE_RESET, CODE_BOLD, CODE_DIM, CODE_ITALIC,
                                    CODE_UNDER, CODE_INVERSE, CODE_STRIKE,
                                    CODE_BOLD_OFF, CODE_NORMAL, CODE_ITALIC_OFF,
                                    CODE_UNDER_OFF, CODE_INVERSE_OFF,
                                    CODE_STRIKE_OFF, CODE_FG_DEFAULT,
                                    CODE_BG_DEFAULT};

  // Directed words; typed expectations only where they are obvious
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{CODE_RESET,       1'b1, 1'b1, '{6'h00, 24'h000000, 24'hE5E5E5}},
    '{CODE_BOLD,        1'b0, 1'b0, '0},
    '{CODE_DIM,         1'b0, 1'b0, '0},
    '{CODE_ITALIC,      1'b0, 1'b0, '0},
    '{CODE_UNDER,       1'b0, 1'b0, '0},
    '{CODE_INVERSE,     1'b0, 1'b0, '0},
    '{CODE_STRIKE,      1'b1, 1'b1, '{6'h3F, 24'h000000, 24'hE5E5E5}},
    '{CODE_NORMAL,      1'b0, 1'b0, '0},
    '{CODE_INVERSE_OFF, 1'b0, 1'b0, '0},
    '{CODE_FG_LAST,     1'b0, 1'b0, '0},
    '{CODE_BG_BRIGHT_LAST, 1'b1, 1'b0, '0},
    '{CODE_FG_EXT,      1'b0, 1'b0, '0},
    '{SEL_INDEXED,      1'b0, 1'b0, '0},
    '{16'd255,          1'b0, 1'b0, '0},
    '{CODE_BG_EXT,      1'b0, 1'b0, '0},
    '{SEL_INDEXED,      1'b0, 1'b0, '0},
    '{16'd256,          1'b1, 1'b1, '{6'h2C, 24'hE5E5E5, 24'hEEEEEE}},
    '{CODE_BG_EXT,      1'b0, 1'b0, '0},
    '{SEL_RGB,          1'b0, 1'b0, '0},
    '{16'hFFFF,         1'b0, 1'b0, '0},
    '{16'd0,            1'b0, 1'b0, '0},
    '{16'd300,          1'b1, 1'b0, '0},
    '{CODE_FG_EXT,      1'b0, 1'b0, '0},
    '{SEL_RGB,          1'b0, 1'b0, '0},
    '{CODE_INVERSE,     1'b1, 1'b0, '0},
    '{CODE_FG_EXT,      1'b1, 1'b0, '0},
    '{16'hFFFF,         1'b1, 1'b0, '0},
    '{CODE_RESET,       1'b1, 1'b1, '{6'h00, 24'h000000, 24'hE5E5E5}}
  };

  sgr_attribute_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sgr_attribute_decoder");
      $finish;
    end
  end

  function automatic logic [7:0] cube_level(input int v);
    return (v == 0) ? 8'd0 : 8'(55 + v * 40);
  endfunction

  // 256-entry palette: base colors, 6x6x6 cube, gray ramp
  function automatic sgr_color_t palette_color(input logic [7:0] idx);
    int c;
    int g;
    if (idx < 8'd16)
      return BASE_COLORS[idx*COLOR_W +: COLOR_W];
    if (idx < 8'd232) begin
      c = int'(idx) - 16;
      return {cube_level(c / 36), cube_level((c / 6) % 6), cube_level(c % 6)};
    end
    g = 8 + (int'(idx) - 232) * 10;
    return {8'(g), 8'(g), 8'(g)};
  endfunction

  function automatic logic [7:0] clamp_channel(input sgr_param_t v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  // Write a color to the target of the open extended form
  function automatic void paint(input sgr_color_t color);
    if (ext_to_bg)
      cur_bg = color;
    else
      cur_fg = color;
  endfunction

  // Apply one ordinary code
  function automatic void apply_code(input sgr_param_t v);
    case (v)
      CODE_RESET: begin
        cur_style = '0;
        cur_fg    = def_fg;
        cur_bg    = def_bg;
      end
      CODE_BOLD:        cur_style[STY_BOLD]   = 1'b1;
      CODE_DIM:         cur_style[STY_DIM]    = 1'b1;
      CODE_ITALIC:      cur_style[STY_ITALIC] = 1'b1;
      CODE_UNDER:       cur_style[STY_UNDER]  = 1'b1;
      CODE_INVERSE:     cur_style[STY_INV]    = 1'b1;
      CODE_STRIKE:      cur_style[STY_STRIKE] = 1'b1;
      CODE_BOLD_OFF:    cur_style[STY_BOLD]   = 1'b0;
      CODE_NORMAL: begin
        cur_style[STY_BOLD] = 1'b0;
        cur_style[STY_DIM]  = 1'b0;
      end
      CODE_ITALIC_OFF:  cur_style[STY_ITALIC] = 1'b0;
      CODE_UNDER_OFF:   cur_style[STY_UNDER]  = 1'b0;
      CODE_INVERSE_OFF: cur_style[STY_INV]    = 1'b0;
      CODE_STRIKE_OFF:  cur_style[STY_STRIKE] = 1'b0;
      CODE_FG_DEFAULT:  cur_fg = def_fg;
      CODE_BG_DEFAULT:  cur_bg = def_bg;
      default: begin
        if (v >= CODE_FG_BASE && v <= CODE_FG_LAST)
          cur_fg = palette_color(8'(v - CODE_FG_BASE));
        else if (v >= CODE_BG_BASE && v <= CODE_BG_LAST)
          cur_bg = palette_color(8'(v - CODE_BG_BASE));
        else if (v >= CODE_FG_BRIGHT && v <= CODE_FG_BRIGHT_LAST)
          cur_fg = palette_color(8'(v - CODE_FG_BRIGHT + BRIGHT_OFS));
        else if (v >= CODE_BG_BRIGHT && v <= CODE_BG_BRIGHT_LAST)
          cur_bg = palette_color(8'(v - CODE_BG_BRIGHT + BRIGHT_OFS));
      end
    endcase
  endfunction

  // Word with no extended form open
  function automatic void start_code(input sgr_param_t v, input logic last);
    ext_phase = PH_IDLE;
    if (v == CODE_FG_EXT || v == CODE_BG_EXT) begin
      if (!last) begin
        ext_phase = PH_INTRO;
        ext_to_bg = (v == CODE_BG_EXT);
      end
    end else begin
      apply_code(v);
    end
  endfunction

  // Word right after 38 / 48
  function automatic void selector_code(input sgr_param_t v, input logic last);
    ext_phase = PH_IDLE;
    if (v == SEL_INDEXED) begin
      if (last)
        paint(def_fg);
      else
        ext_phase = PH_INDEX;
    end else if (v == SEL_RGB) begin
      if (last) begin
        paint(def_fg);
        apply_code(CODE_DIM);
      end else begin
        ext_phase = PH_RGB;
        held_n    = 2'd0;
      end
    end else begin
      start_code(v, last);
    end
  endfunction

  // Advance the model by one word; return 1 with the attributes at a last word
  function automatic logic take_param(input sgr_param_t v, input logic last,
                                      output sgr_attr_t attr);
    logic [1:0] n;
    sgr_param_t h0;
    case (ext_phase)
      PH_INTRO: selector_code(v, last);
      PH_INDEX: begin
        ext_phase = PH_IDLE;
        paint((v < 16'd256) ? palette_color(v[7:0]) : def_fg);
      end
      PH_RGB: begin
        if (held_n >= 2'd2) begin
          ext_phase = PH_IDLE;
          held_n    = 2'd0;
          paint({clamp_channel(held_w[0]), clamp_channel(held_w[1]), clamp_channel(v)});
        end else if (last) begin
          // truncated RGB form: fall back, then replay the held words
          n         = held_n;
          h0        = held_w[0];
          ext_phase = PH_IDLE;
          held_n    = 2'd0;
          paint(def_fg);
          apply_code(CODE_DIM);
          if (n >= 2'd1)
            start_code(h0, 1'b0);
          if (ext_phase == PH_INTRO)
            selector_code(v, 1'b1);
          else
            start_code(v, 1'b1);
        end else begin
          held_w[held_n[0]] = v;
          held_n = held_n + 2'd1;
        end
      end
      default: start_code(v, last);
    endcase
    attr = '{cur_style, cur_bg, cur_fg};
    if (last) begin
      ext_phase = PH_IDLE;
      held_n    = 2'd0;
    end
    return last;
  endfunction

  function automatic void check_attr(input sgr_attr_t want, input sgr_attr_t got);
    if (want.fg !== got.fg) begin
      $display("%0t: fg_color expected %h got %h", $time, want.fg, got.fg);
      errors++;
    end
    if (want.bg !== got.bg) begin
      $display("%0t: bg_color expected %h got %h", $time, want.bg, got.bg);
      errors++;
    end
    for (int i = 0; i < STYLE_W; i++) begin
      if (want.style[i] !== got.style[i]) begin
        $display("%0t: %s expected %b got %b", $time, style_names[i],
                 want.style[i], got.style[i]);
        errors++;
      end
    end
  endfunction

  // Output side: check accepted words, random backpressure, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (attr_q.size() == 0) begin
        $display("%0t: unexpected attribute word, expected none got %h", $time,
                 out_tdata);
        errors++;
      end else begin
        check_attr(attr_q[0], sgr_attr_t'(out_tdata[ATTR_W-1:0]));
        attr_q.delete(0);
      end
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offer one word, wait for acceptance, then advance the model
  task automatic send_word(input sgr_param_t v, input logic last,
                           input logic typed, input sgr_attr_t typed_attr);
    sgr_attr_t attr;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    items_sent++;
    if (take_param(v, last, attr))
      attr_q.insert(attr_q.size(), typed ? typed_attr : attr);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline settle
  task automatic drain;
    in_tvalid <= 1'b0;
    while (attr_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_defaults(input sgr_color_t fg, input sgr_color_t bg);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DEF_FG;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_addr  <= CFG_DEF_BG;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    def_fg = fg;
    def_bg = bg;
  endtask

  function automatic sgr_param_t ext_intro();
    return $urandom_range(0, 1) ? CODE_BG_EXT : CODE_FG_EXT;
  endfunction

  function automatic sgr_param_t pick_code();
    case ($urandom_range(0, 6))
      0:       return style_codes[$urandom_range(0, 14)];
      1:       return CODE_FG_BASE + sgr_param_t'($urandom_range(0, 7));
      2:       return CODE_BG_BASE + sgr_param_t'($urandom_range(0, 7));
      3:       return CODE_FG_BRIGHT + sgr_param_t'($urandom_range(0, 7));
      4:       return CODE_BG_BRIGHT + sgr_param_t'($urandom_range(0, 7));
      5:       return ext_intro();
      default: return sgr_param_t'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic sgr_param_t pick_channel();
    case ($urandom_range(0, 3))
      0, 1:    return sgr_param_t'($urandom_range(0, 255));
      2:       return pick_code();
      default: return sgr_param_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Build and send one random SGR sequence
  task automatic send_random_sequence;
    sgr_param_t seq [$];
    int         kind;
    int         cut;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      repeat ($urandom_range(1, 4)) seq.insert(seq.size(), pick_code());
    end else if (kind < 55) begin
      if ($urandom_range(0, 1)) seq.insert(seq.size(), pick_code());
      seq.insert(seq.size(), ext_intro());
      seq.insert(seq.size(), SEL_INDEXED);
      seq.insert(seq.size(),
                 sgr_param_t'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 255)
                                                           : $urandom_range(256, 65535)));
      if ($urandom_range(0, 1)) seq.insert(seq.size(), pick_code());
    end else if (kind < 75) begin
      if ($urandom_range(0, 1)) seq.insert(seq.size(), pick_code());
      seq.insert(seq.size(), ext_intro());
      seq.insert(seq.size(), SEL_RGB);
      repeat (3) seq.insert(seq.size(), pick_channel());
      if ($urandom_range(0, 1)) seq.insert(seq.size(), pick_code());
    end else if (kind < 90) begin
      // extended form cut short, or followed by a foreign selector
      seq.insert(seq.size(), ext_intro());
      cut = $urandom_range(0, 5);
      case (cut)
        1: seq.insert(seq.size(), SEL_INDEXED);
        2: seq.insert(seq.size(), SEL_RGB);
        3, 4: begin
          seq.insert(seq.size(), SEL_RGB);
          repeat (cut - 2) seq.insert(seq.size(), pick_channel());
        end
        5: repeat ($urandom_range(1, 2)) seq.insert(seq.size(), pick_code());
        default: ;
      endcase
    end else begin
      if ($urandom_range(0, 4) == 0)
        seq.insert(seq.size(), CODE_RESET);
      else
        repeat ($urandom_range(1, 4))
          seq.insert(seq.size(), sgr_param_t'($urandom_range(0, 65535)));
    end
    foreach (seq[i])
      send_word(seq[i], i == seq.size() - 1, 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    int         phase_start;
    sgr_color_t fg;
    sgr_color_t bg;
    def_fg    = DEF_FG_RESET;
    def_bg    = DEF_BG_RESET;
    cur_fg    = DEF_FG_RESET;
    cur_bg    = DEF_BG_RESET;
    cur_style = '0;
    ext_phase = PH_IDLE;
    ext_to_bg = 1'b0;
    held_n    = 2'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table with reset defaults
    for (int r = 0; r < NUM_ROWS; r++)
      send_word(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                dir_rows[r].attr);
    drain();

    // random sequences over several default color settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin fg = 24'h000000; bg = 24'h000000; end
        1: begin fg = 24'hFFFFFF; bg = 24'hFFFFFF; end
        2: begin fg = 24'hFFFFFF; bg = 24'h000000; end
        default: begin
          fg = sgr_color_t'($urandom_range(0, 24'hFFFFFF));
          bg = sgr_color_t'($urandom_range(0, 24'hFFFFFF));
        end
      endcase
      write_defaults(fg, bg);
      hold_req = hold_req || (p == 1);
      calm     = (p == 3);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS)
        send_random_sequence();
      drain();
    end
    calm = 1'b0;

    if (errors == 0)
      $display("PASS sgr_attribute_decoder");
    else
      $display("FAIL sgr_attribute_decoder");
    $finish;
  end

endmodule

// ----- files.f -----
sv/sgr_pkg.sv
sv/sgr_palette.sv
sv/sgr_decode.sv
sv/sgr_attribute_decoder.sv
tb/tb_sgr_attribute_decoder.sv
